### src/text_console_char_writer_unit_assert.svh
// ----------------------------------------------------------------------------
// text_console_char_writer_unit_assert
// Assertion macros used by the text console writer datapath.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCCW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCCW_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Types and fixed constants of the text console character writer.
// ----------------------------------------------------------------------------
`default_nettype none
package tccw_pkg;

	localparam int COL_W      = 9;
	localparam int ROW_W      = 7;
	localparam int HGT_W      = 8;
	localparam int CHR_W      = 16;
	localparam int ATR_W      = 16;
	localparam int CELL_W     = 32;
	localparam int S_DATA_W   = 56;
	localparam int S_USER_W   = 2;
	localparam int M_DATA_W   = 72;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [COL_W-1:0] MIN_COLS   = 9'd24;
	localparam logic [HGT_W-1:0] MIN_ROWS   = 8'd12;
	localparam logic [CHR_W-1:0] CH_BELL    = 16'd7;
	localparam logic [CHR_W-1:0] CH_BS      = 16'd8;
	localparam logic [CHR_W-1:0] CH_TAB     = 16'd9;
	localparam logic [CHR_W-1:0] CH_LF      = 16'd10;
	localparam logic [CHR_W-1:0] CH_CR      = 16'd13;
	localparam logic [CHR_W-1:0] CH_SPACE   = 16'h0020;
	localparam logic [ATR_W-1:0] RESET_ATTR = 16'd7;

	localparam logic [1:0] OP_WRITE     = 2'd0;
	localparam logic [1:0] OP_FILL_CHAR = 2'd1;
	localparam logic [1:0] OP_FILL_ATTR = 2'd2;
	localparam logic [1:0] OP_READ      = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_PROC   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 3'd6;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_ACCEPT,
		CMD_RD_CELL,
		CMD_CAP,
		CMD_TAB_Q,
		CMD_TAB_R,
		CMD_WRAP_ROW,
		CMD_CLAMP,
		CMD_BS,
		CMD_CR,
		CMD_LF,
		CMD_PUT,
		CMD_RMW_RD,
		CMD_RMW_WR,
		CMD_SCR_INIT,
		CMD_COPY,
		CMD_DRAIN,
		CMD_BLANK,
		CMD_FINISH
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic op_read;
		logic is_bell;
		logic is_tab;
		logic is_bs;
		logic is_cr;
		logic is_lf;
		logic is_w;
		logic col_ge_w;
		logic wrap_ok;
		logic cur_in;
		logic step_scroll;
		logic tab_done;
		logic copy_last;
		logic blank_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

### src/tccw_cell_ram.sv
// ----------------------------------------------------------------------------
// tccw_cell_ram
// Cell store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tccw_cell_ram
	import tccw_pkg::*;
#(
	parameter int AW = 15
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [CELL_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### src/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// tccw_ctrl
// Sequencer: steps items through read, wrap, action, tab repeat and scroll.
// ----------------------------------------------------------------------------
`default_nettype none
module tccw_ctrl
	import tccw_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_READ_WAIT,
		ST_TAB_Q,
		ST_TAB_R,
		ST_WRAP,
		ST_ACT,
		ST_RMW,
		ST_CHECK,
		ST_SCR_INIT,
		ST_SCR_COPY,
		ST_SCR_DRAIN,
		ST_SCR_BLANK,
		ST_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   ret_act_q, ret_act_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d   = state_q;
		ret_act_d = ret_act_q;
		cmd       = CMD_NONE;
		case (state_q)
			ST_CLEAR: begin
				cmd = CMD_CLEAR;
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd     = CMD_ACCEPT;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (sts.op_read) begin
					cmd     = CMD_RD_CELL;
					state_d = ST_READ_WAIT;
				end else if (sts.is_bell) begin
					state_d = ST_FINISH;
				end else if (sts.is_tab) begin
					state_d = ST_TAB_Q;
				end else begin
					state_d = ST_WRAP;
				end
			end
			ST_READ_WAIT: begin
				cmd     = CMD_CAP;
				state_d = ST_FINISH;
			end
			ST_TAB_Q: begin
				cmd     = CMD_TAB_Q;
				state_d = ST_TAB_R;
			end
			ST_TAB_R: begin
				cmd     = CMD_TAB_R;
				state_d = ST_WRAP;
			end
			ST_WRAP: begin
				state_d = ST_ACT;
				if (sts.col_ge_w) begin
					if (sts.wrap_ok) begin
						cmd = CMD_WRAP_ROW;
						if (sts.step_scroll) begin
							ret_act_d = 1'b1;
							state_d   = ST_SCR_INIT;
						end
					end else begin
						cmd = CMD_CLAMP;
					end
				end
			end
			ST_ACT: begin
				state_d = ST_CHECK;
				if (sts.is_bs) begin
					cmd = CMD_BS;
				end else if (sts.is_cr) begin
					cmd = CMD_CR;
				end else if (sts.is_lf) begin
					cmd = CMD_LF;
					if (sts.step_scroll) begin
						ret_act_d = 1'b0;
						state_d   = ST_SCR_INIT;
					end
				end else if (sts.is_w || !sts.cur_in) begin
					cmd = CMD_PUT;
				end else begin
					// Fill operations change one half of the cell, so fetch it first.
					cmd     = CMD_RMW_RD;
					state_d = ST_RMW;
				end
			end
			ST_RMW: begin
				cmd     = CMD_RMW_WR;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.is_tab && !sts.tab_done) state_d = ST_WRAP;
				else state_d = ST_FINISH;
			end
			ST_SCR_INIT: begin
				cmd     = CMD_SCR_INIT;
				state_d = ST_SCR_COPY;
			end
			ST_SCR_COPY: begin
				cmd = CMD_COPY;
				if (sts.copy_last) state_d = ST_SCR_DRAIN;
			end
			ST_SCR_DRAIN: begin
				cmd     = CMD_DRAIN;
				state_d = ST_SCR_BLANK;
			end
			ST_SCR_BLANK: begin
				cmd = CMD_BLANK;
				if (sts.blank_last) state_d = ret_act_q ? ST_ACT : ST_CHECK;
			end
			ST_FINISH: begin
				cmd = CMD_FINISH;
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			ret_act_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ret_act_q <= ret_act_d;
		end
	end

endmodule
`default_nettype wire

### src/tccw_dp.sv
// ----------------------------------------------------------------------------
// tccw_dp
// Datapath: configuration, cursor, run count, cell store, scroll counters
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_char_writer_unit_assert.svh"
module tccw_dp
	import tccw_pkg::*;
#(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 128,
	parameter int TAB_STOP = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	input  wire logic [S_DATA_W-1:0]   s_tdata,
	input  wire logic [S_USER_W-1:0]   s_tuser,
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [M_DATA_W-1:0]   m_tdata,
	output logic                       m_tlast,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CIW    = $clog2(MAX_COLS);
	localparam int RIW    = $clog2(MAX_ROWS);
	localparam int AW     = RIW + CIW;
	localparam int PH_W   = $clog2(TAB_STOP);
	localparam int TAB_SH = 16;
	localparam int TAB_RCP = ((1 << TAB_SH) + TAB_STOP - 1) / TAB_STOP;
	localparam int PRD_W  = COL_W + TAB_SH + 1;

	// Configuration registers.
	logic             proc_q, wrap_q;
	logic [ATR_W-1:0] cattr_q;
	logic [COL_W-1:0] swidth_q;
	logic [HGT_W-1:0] sheight_q;
	logic [ROW_W-1:0] stop_q, sbot_q;

	// Item registers.
	logic [1:0]       op_q;
	logic [CHR_W-1:0] ch_q;
	logic [ATR_W-1:0] at_q;
	logic             last_q;
	logic [COL_W-1:0] px_q;
	logic [ROW_W-1:0] py_q;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [15:0]      run_q;
	logic [PH_W-1:0]  phase_q;
	logic [COL_W-1:0] tq_q;
	logic [ROW_W-1:0] sr_q;
	logic [COL_W-1:0] sc_q;
	logic             pend_q;
	logic [AW-1:0]    pend_addr_q;
	logic [AW-1:0]    clr_q;
	logic             scr_q;
	logic [CHR_W-1:0] rch_q;
	logic [ATR_W-1:0] rat_q;

	logic             out_valid_q;
	logic [COL_W-1:0] o_col_q;
	logic [ROW_W-1:0] o_row_q;
	logic             o_cnt_q, o_scr_q, o_end_q;
	logic [15:0]      o_run_q;
	logic [CHR_W-1:0] o_rch_q;
	logic [ATR_W-1:0] o_rat_q;

	logic [COL_W-1:0]  used_w;
	logic [HGT_W-1:0]  used_h;
	logic [HGT_W-1:0]  bot_p1, rgn_end, row_p1;
	logic              is_w, pbell, pbs, pcr, plf, ptab, counted;
	logic              col_ge_w, step_keeps, can_scroll, cur_in, rd_in, out_free;
	logic [CHR_W-1:0]  put_ch;
	logic [15:0]       run_nx;
	logic [PH_W-1:0]   phase_inc;
	logic [PRD_W-1:0]  tq_prod;
	logic [COL_W-1:0]  tq_mul, rem0, rem;
	logic [AW-1:0]     cur_addr, rd_addr_in, copy_addr, blank_addr, sr_sc_addr;
	logic [ROW_W-1:0]  sr_p1, last_row;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;

	// Clamped screen size and the row after the scroll region.
	always_comb begin
		if (swidth_q < MIN_COLS) used_w = MIN_COLS;
		else if (int'(swidth_q) > MAX_COLS) used_w = COL_W'(MAX_COLS);
		else used_w = swidth_q;
		if (sheight_q < MIN_ROWS) used_h = MIN_ROWS;
		else if (int'(sheight_q) > MAX_ROWS) used_h = HGT_W'(MAX_ROWS);
		else used_h = sheight_q;
	end

	assign bot_p1  = HGT_W'(sbot_q) + HGT_W'(1);
	assign rgn_end = (bot_p1 < used_h) ? bot_p1 : used_h;
	assign row_p1  = HGT_W'(row_q) + HGT_W'(1);

	assign is_w    = (op_q == OP_WRITE);
	assign pbell   = is_w && proc_q && (ch_q == CH_BELL);
	assign pbs     = is_w && proc_q && (ch_q == CH_BS);
	assign pcr     = is_w && proc_q && (ch_q == CH_CR);
	assign plf     = is_w && proc_q && (ch_q == CH_LF);
	assign ptab    = is_w && proc_q && (ch_q == CH_TAB);
	assign put_ch  = ptab ? CH_SPACE : ch_q;
	assign counted = (op_q != OP_READ) && !pbell;
	assign run_nx  = (counted && (run_q != 16'hFFFF)) ? run_q + 16'd1 : run_q;

	assign col_ge_w   = (col_q >= used_w);
	assign step_keeps = (row_p1 >= rgn_end);
	assign can_scroll = ((HGT_W'(stop_q) + HGT_W'(2)) <= rgn_end);
	assign cur_in     = (col_q < used_w) && (HGT_W'(row_q) < used_h);
	assign rd_in      = (px_q < used_w) && (HGT_W'(py_q) < used_h);
	assign out_free   = !out_valid_q || m_tready;

	assign phase_inc = (phase_q == PH_W'(TAB_STOP - 1)) ? '0 : phase_q + PH_W'(1);

	// Column modulo the tab stop: reciprocal multiply, then remainder.
	assign tq_prod = PRD_W'(col_q) * PRD_W'(TAB_RCP);
	assign tq_mul  = COL_W'(tq_q * COL_W'(TAB_STOP));
	assign rem0    = col_q - tq_mul;
	assign rem     = (rem0 >= COL_W'(TAB_STOP)) ? rem0 - COL_W'(TAB_STOP) : rem0;

	assign sr_p1      = sr_q + ROW_W'(1);
	assign last_row   = ROW_W'(rgn_end - HGT_W'(1));
	assign cur_addr   = {RIW'(row_q), CIW'(col_q)};
	assign rd_addr_in = {RIW'(py_q), CIW'(px_q)};
	assign copy_addr  = {RIW'(sr_p1), CIW'(sc_q)};
	assign sr_sc_addr = {RIW'(sr_q), CIW'(sc_q)};
	assign blank_addr = {RIW'(last_row), CIW'(sc_q)};

	always_comb begin
		sts.clear_last  = &clr_q;
		sts.op_read     = (op_q == OP_READ);
		sts.is_bell     = pbell;
		sts.is_tab      = ptab;
		sts.is_bs       = pbs;
		sts.is_cr       = pcr;
		sts.is_lf       = plf;
		sts.is_w        = is_w;
		sts.col_ge_w    = col_ge_w;
		sts.wrap_ok     = !is_w || (wrap_q && !pcr && !plf);
		sts.cur_in      = cur_in;
		sts.step_scroll = step_keeps && can_scroll;
		sts.tab_done    = (phase_q == '0) || (!wrap_q && col_ge_w);
		sts.copy_last   = ((HGT_W'(sr_q) + HGT_W'(2)) == rgn_end) &&
			(sc_q == used_w - COL_W'(1));
		sts.blank_last  = (sc_q == used_w - COL_W'(1));
		sts.out_free    = out_free;
	end

	// Store port selection. A pending copy write owns the write port.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_addr;
		ram_wdata = {cattr_q, put_ch};
		ram_re    = 1'b0;
		ram_raddr = cur_addr;
		if (pend_q) begin
			ram_we    = 1'b1;
			ram_waddr = pend_addr_q;
			ram_wdata = ram_rdata;
		end else begin
			case (cmd)
				CMD_CLEAR: begin
					ram_we    = 1'b1;
					ram_waddr = clr_q;
					ram_wdata = {RESET_ATTR, CH_SPACE};
				end
				CMD_PUT: begin
					ram_we = is_w && cur_in;
				end
				CMD_RMW_WR: begin
					ram_we = 1'b1;
					if (op_q == OP_FILL_CHAR) ram_wdata = {ram_rdata[CELL_W-1:CHR_W], ch_q};
					else ram_wdata = {at_q, ram_rdata[CHR_W-1:0]};
				end
				CMD_BLANK: begin
					ram_we    = 1'b1;
					ram_waddr = blank_addr;
					ram_wdata = {cattr_q, CH_SPACE};
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end
		case (cmd)
			CMD_RD_CELL: begin
				ram_re    = 1'b1;
				ram_raddr = rd_addr_in;
			end
			CMD_RMW_RD: begin
				ram_re = 1'b1;
			end
			CMD_COPY: begin
				ram_re    = 1'b1;
				ram_raddr = copy_addr;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	tccw_cell_ram #(
		.AW(AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_q    <= 1'b1;
			wrap_q    <= 1'b1;
			cattr_q   <= RESET_ATTR;
			swidth_q  <= 9'd80;
			sheight_q <= 8'd25;
			stop_q    <= 7'd0;
			sbot_q    <= 7'd127;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PROC:   proc_q    <= cfg_data[0];
				CFG_WRAP:   wrap_q    <= cfg_data[0];
				CFG_ATTR:   cattr_q   <= cfg_data;
				CFG_WIDTH:  swidth_q  <= cfg_data[COL_W-1:0];
				CFG_HEIGHT: sheight_q <= cfg_data[HGT_W-1:0];
				CFG_TOP:    stop_q    <= cfg_data[ROW_W-1:0];
				CFG_BOTTOM: sbot_q    <= cfg_data[ROW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Item payload.
	always_ff @(posedge clk) begin
		if (cmd == CMD_ACCEPT) begin
			op_q   <= s_tuser;
			ch_q   <= s_tdata[15:0];
			at_q   <= s_tdata[31:16];
			px_q   <= s_tdata[42:34];
			py_q   <= s_tdata[49:43];
			last_q <= s_tlast;
		end
		case (cmd)
			CMD_TAB_Q: tq_q <= tq_prod[TAB_SH +: COL_W];
			default: begin
			end
		endcase
		pend_addr_q <= sr_sc_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			run_q   <= '0;
			phase_q <= '0;
			sr_q    <= '0;
			sc_q    <= '0;
			pend_q  <= 1'b0;
			clr_q   <= '0;
			scr_q   <= 1'b0;
			rch_q   <= '0;
			rat_q   <= '0;
		end else begin
			pend_q <= (cmd == CMD_COPY);
			case (cmd)
				CMD_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				CMD_ACCEPT: begin
					scr_q <= 1'b0;
					rch_q <= '0;
					rat_q <= '0;
					if (s_tdata[33]) run_q <= '0;
					if (s_tdata[32]) begin
						col_q <= s_tdata[42:34];
						row_q <= s_tdata[49:43];
					end
				end
				CMD_CAP: begin
					if (rd_in) begin
						rch_q <= ram_rdata[CHR_W-1:0];
						rat_q <= ram_rdata[CELL_W-1:CHR_W];
					end
				end
				CMD_TAB_R: begin
					phase_q <= PH_W'(rem);
				end
				CMD_WRAP_ROW: begin
					col_q   <= '0;
					phase_q <= '0;
					if (!step_keeps) row_q <= row_q + ROW_W'(1);
				end
				CMD_CLAMP: begin
					col_q <= used_w - COL_W'(1);
				end
				CMD_BS: begin
					if (col_q != '0) col_q <= col_q - COL_W'(1);
				end
				CMD_CR: begin
					col_q <= '0;
				end
				CMD_LF: begin
					col_q <= '0;
					if (!step_keeps) row_q <= row_q + ROW_W'(1);
				end
				CMD_PUT, CMD_RMW_WR: begin
					col_q   <= col_q + COL_W'(1);
					phase_q <= phase_inc;
				end
				CMD_SCR_INIT: begin
					sr_q  <= stop_q;
					sc_q  <= '0;
					scr_q <= 1'b1;
				end
				CMD_COPY: begin
					if (sc_q == used_w - COL_W'(1)) begin
						sc_q <= '0;
						sr_q <= sr_p1;
					end else begin
						sc_q <= sc_q + COL_W'(1);
					end
				end
				CMD_DRAIN: begin
					sc_q <= '0;
				end
				CMD_BLANK: begin
					sc_q <= sc_q + COL_W'(1);
				end
				CMD_FINISH: begin
					if (out_free) run_q <= run_nx;
				end
				default: begin
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd == CMD_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_FINISH && out_free) begin
			o_col_q <= col_q;
			o_row_q <= row_q;
			o_cnt_q <= counted;
			o_scr_q <= scr_q;
			o_run_q <= run_nx;
			o_end_q <= last_q;
			o_rch_q <= rch_q;
			o_rat_q <= rat_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = o_end_q;
	assign m_tdata  = {6'b0, o_rat_q, o_rch_q, o_run_q, o_scr_q, o_cnt_q, o_row_q, o_col_q};

	`TCCW_ASSERT_IMP(a_wport_free, clk, arst_n, pend_q,
		!(cmd == CMD_PUT || cmd == CMD_RMW_WR || cmd == CMD_BLANK || cmd == CMD_CLEAR),
		"copy write collides with another store write")
	`TCCW_ASSERT_IMP(a_copy_in_region, clk, arst_n, cmd == CMD_COPY,
		(HGT_W'(sr_q) + HGT_W'(1)) < rgn_end, "scroll copy reads outside the region")
	`TCCW_ASSERT_NXT(a_result_loaded, clk, arst_n, (cmd == CMD_FINISH) && out_free,
		m_tvalid, "finished item did not reach the result register")

endmodule
`default_nettype wire

### src/text_console_char_writer_unit.sv
// Text console writer. Each item writes, fills or reads a screen cell, or acts
// as a control character, and returns the cursor after it. After reset the
// block clears all 2**(clog2(MAX_ROWS) + clog2(MAX_COLS)) cells of the store
// (32768 at the default size), one cell per cycle, and takes no item
// meanwhile. A fill of a cell on screen reads the cell before writing it
// back, and a processed tab writes spaces up to the next tab stop. A scroll
// copies the region through the single store port pair at one cell per cycle
// and then blanks the bottom row. The result waits in an output register,
// so the next item is taken while it is still pending; that item cannot
// finish until the pending result has been taken.
// ----------------------------------------------------------------------------
// text_console_char_writer_unit
// Top level: sequencer and datapath of the text console character writer.
// ----------------------------------------------------------------------------
`default_nettype none
module text_console_char_writer_unit
	import tccw_pkg::*;
#(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 128,
	parameter int TAB_STOP = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// char_code[15:0], attr_value[31:16], load_position[32], start_run[33],
	// pos_x[42:34], pos_y[49:43], zero[55:50]
	input  wire logic [S_DATA_W-1:0]   s_tdata,
	// operation[1:0]
	input  wire logic [S_USER_W-1:0]   s_tuser,
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// cursor_x[8:0], cursor_y[15:9], counted[16], scrolled[17], run_total[33:18],
	// read_char[49:34], read_attr[65:50], zero[71:66]
	output logic      [M_DATA_W-1:0]   m_tdata,
	output logic                       m_tlast,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	tccw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	tccw_dp #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS),
		.TAB_STOP(TAB_STOP)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

endmodule
`default_nettype wire
